// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; the guard keeps a second inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/vcsm_pkg.sv -----
// Shared types and constants for the volume crop / sphere mask block.
// No dependencies; imported by the register file and the top level.
`default_nettype none

package vcsm_pkg;

   localparam int DEF_COORD_BITS    = 12;
   localparam int DEF_SPHERE_MARGIN = 5;
   localparam int REG_W             = 13;
   localparam int RADIUS_W          = 11;
   localparam int VOXEL_W           = 8;
   localparam int NUM_AXES          = 3;
   localparam int CSR_ADDR_W        = 5;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_IDX_LSB       = 2;

   typedef enum logic [2:0] {
      CSR_MODE,
      CSR_LOW_X,
      CSR_HIGH_X,
      CSR_LOW_Y,
      CSR_HIGH_Y,
      CSR_LOW_Z,
      CSR_HIGH_Z,
      CSR_RADIUS
   } csr_index_type;

   typedef enum logic {
      MODE_BOX,
      MODE_SPHERE
   } mode_type;

   // Register contents as seen by the datapath; low doubles as sphere centre.
   typedef struct packed {
      mode_type                           mode;
      logic [NUM_AXES-1:0][REG_W-1:0]     low;
      logic [NUM_AXES-1:0][REG_W-1:0]     high;
      logic [RADIUS_W-1:0]                radius;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/vcsm_csr.sv -----
// Configuration register file with an APB-style write/read port.
// Depends on vcsm_pkg for the register map and the cfg_type struct.
`default_nettype none

module vcsm_csr
   import vcsm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready,
   output cfg_type                     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type idx;
   logic          wr_en;

   assign idx    = csr_index_type'(paddr[CSR_ADDR_W-1:CSR_IDX_LSB]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_MODE:   cfg_in.mode      = mode_type'(pwdata[0]);
            CSR_LOW_X:  cfg_in.low[0]    = pwdata[REG_W-1:0];
            CSR_HIGH_X: cfg_in.high[0]   = pwdata[REG_W-1:0];
            CSR_LOW_Y:  cfg_in.low[1]    = pwdata[REG_W-1:0];
            CSR_HIGH_Y: cfg_in.high[1]   = pwdata[REG_W-1:0];
            CSR_LOW_Z:  cfg_in.low[2]    = pwdata[REG_W-1:0];
            CSR_HIGH_Z: cfg_in.high[2]   = pwdata[REG_W-1:0];
            CSR_RADIUS: cfg_in.radius    = pwdata[RADIUS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_BOX;
         cfg_ff.low    <= '1;
         cfg_ff.high   <= '1;
         cfg_ff.radius <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Bounds read back sign-extended.
   always_comb begin
      unique case (idx)
         CSR_MODE:   prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.mode};
         CSR_LOW_X:  prdata = {{(CSR_DATA_W-REG_W){cfg_ff.low[0][REG_W-1]}}, cfg_ff.low[0]};
         CSR_HIGH_X: prdata = {{(CSR_DATA_W-REG_W){cfg_ff.high[0][REG_W-1]}}, cfg_ff.high[0]};
         CSR_LOW_Y:  prdata = {{(CSR_DATA_W-REG_W){cfg_ff.low[1][REG_W-1]}}, cfg_ff.low[1]};
         CSR_HIGH_Y: prdata = {{(CSR_DATA_W-REG_W){cfg_ff.high[1][REG_W-1]}}, cfg_ff.high[1]};
         CSR_LOW_Z:  prdata = {{(CSR_DATA_W-REG_W){cfg_ff.low[2][REG_W-1]}}, cfg_ff.low[2]};
         CSR_HIGH_Z: prdata = {{(CSR_DATA_W-REG_W){cfg_ff.high[2][REG_W-1]}}, cfg_ff.high[2]};
         CSR_RADIUS: prdata = {{(CSR_DATA_W-RADIUS_W){1'b0}}, cfg_ff.radius};
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/volume_crop_sphere_mask.sv -----
// Region-of-interest crop of a raster voxel stream, box or sphere with mask.
// Depends on vcsm_pkg and vcsm_csr.
//
// Usage:
//   req_* carries one voxel per request in raster order (x fastest, then y,
//   then z): tdata = voxel, tuser = {slice_end, row_end}, tlast = volume end.
//   rsp_* carries the voxels inside the crop: tdata = voxel (zero outside the
//   sphere in sphere mode), tlast = last voxel of the crop. Voxels outside
//   the crop produce no response.
//   csr_* programs mode, bounds / centre and radius; write it only while idle.
// Timing:
//   Three register stages: input capture, per-axis compare and squares, then
//   the squared-distance sum and the output register. An accepted request
//   moves through the capture, lane and output registers in that order;
//   one request per cycle is taken while the response side is not stalled.
//   All stages advance together: when rsp_tready is low with a response
//   held, req_tready drops and the pipeline freezes in place.
// Reset: clears the position counters and pipeline valids; the registers
//   return to box mode with every bound negative (full volume) and radius 0.
`default_nettype none

module volume_crop_sphere_mask
   import vcsm_pkg::*;
#(
   parameter int COORD_BITS    = DEF_COORD_BITS,
   parameter int SPHERE_MARGIN = DEF_SPHERE_MARGIN
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [VOXEL_W-1:0]     req_tdata,   // [7:0] voxel_in
   input  wire logic [1:0]             req_tuser,   // [0] row_end, [1] slice_end
   input  wire logic                   req_tlast,   // volume_end
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [VOXEL_W-1:0]     rsp_tdata,   // [7:0] voxel_out
   output logic                        rsp_tlast,   // crop_last
   // configuration port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   // Signed working width: holds any position and centre +/- (radius + margin).
   localparam int CW   = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 3;
   localparam int SQW  = 2 * CW;
   localparam int SUMW = SQW + 2;
   localparam int RSQW = 2 * RADIUS_W;
   localparam logic signed [CW-1:0] MARGIN_S    = CW'(SPHERE_MARGIN);
   localparam logic signed [CW-1:0] MARGIN_M1_S = CW'(SPHERE_MARGIN - 1);

   cfg_type cfg;

   vcsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   logic advance;
   logic accept;
   logic [NUM_AXES-1:0] req_ends;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid & advance;
   assign req_ends   = {req_tlast, req_tuser[1], req_tuser[0]};

   // ---------------- position counters ----------------
   logic [NUM_AXES-1:0][COORD_BITS-1:0] pos_ff;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         priority if (req_ends[2]) begin
            pos_in = '0;
         end else if (req_ends[1]) begin
            pos_in[0] = '0;
            pos_in[1] = '0;
            pos_in[2] = pos_ff[2] + 1'b1;
         end else if (req_ends[0]) begin
            pos_in[0] = '0;
            pos_in[1] = pos_ff[1] + 1'b1;
         end else begin
            pos_in[0] = pos_ff[0] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // ---------------- stage 1: capture ----------------
   logic                                s1_valid_ff;
   logic [VOXEL_W-1:0]                  s1_voxel_ff;
   logic [NUM_AXES-1:0]                 s1_ends_ff;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] s1_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_voxel_ff <= req_tdata;
         s1_ends_ff  <= req_ends;
         s1_pos_ff   <= pos_ff;
      end
   end

   // ---------------- stage 2: per-axis lanes ----------------
   logic                          sphere;
   logic [NUM_AXES-1:0]           lane_in;
   logic [NUM_AXES-1:0]           lane_last;
   logic [NUM_AXES-1:0][SQW-1:0]  lane_sq;
   logic signed [CW-1:0]          r_s;

   assign sphere = (cfg.mode == MODE_SPHERE);
   assign r_s    = {{(CW-RADIUS_W){1'b0}}, cfg.radius};

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [CW-1:0]  c_s;
      logic signed [CW-1:0]  hb_s;
      logic signed [CW-1:0]  p_s;
      logic signed [CW-1:0]  sph_lo;
      logic signed [CW-1:0]  sph_hi;
      logic signed [CW-1:0]  d_s;
      logic signed [SQW-1:0] sq_s;
      logic                  box_free;

      assign c_s    = {{(CW-REG_W){cfg.low[a][REG_W-1]}}, cfg.low[a]};
      assign hb_s   = {{(CW-REG_W){cfg.high[a][REG_W-1]}}, cfg.high[a]};
      assign p_s    = {{(CW-COORD_BITS){1'b0}}, s1_pos_ff[a]};
      assign sph_lo = c_s - (r_s + MARGIN_S);
      assign sph_hi = c_s + r_s + MARGIN_M1_S;
      assign d_s    = p_s - c_s;
      assign sq_s   = d_s * d_s;
      // a negative bound opens the axis; its end comes from the stream marks
      assign box_free = cfg.low[a][REG_W-1] | cfg.high[a][REG_W-1];

      always_comb begin
         if (sphere) begin
            lane_in[a]   = (p_s >= sph_lo) && (p_s <= sph_hi);
            lane_last[a] = (p_s == sph_hi);
         end else if (box_free) begin
            lane_in[a]   = 1'b1;
            lane_last[a] = s1_ends_ff[a];
         end else begin
            lane_in[a]   = (p_s >= c_s) && (p_s <= hb_s);
            lane_last[a] = (p_s == hb_s);
         end
      end

      assign lane_sq[a] = unsigned'(sq_s);
   end

   logic                          s2_valid_ff;
   logic                          s2_inside_ff;
   logic                          s2_last_ff;
   logic                          s2_sphere_ff;
   logic [VOXEL_W-1:0]            s2_voxel_ff;
   logic [NUM_AXES-1:0][SQW-1:0]  s2_sq_ff;
   logic [RSQW-1:0]               s2_rsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_inside_ff <= &lane_in;
         s2_last_ff   <= &lane_last;
         s2_sphere_ff <= sphere;
         s2_voxel_ff  <= s1_voxel_ff;
         s2_sq_ff     <= lane_sq;
         s2_rsq_ff    <= cfg.radius * cfg.radius;
      end
   end

   // ---------------- stage 3: distance check and output ----------------
   logic [SUMW-1:0] dist2;
   logic            masked;

   assign dist2  = SUMW'(s2_sq_ff[0]) + SUMW'(s2_sq_ff[1]) + SUMW'(s2_sq_ff[2]);
   assign masked = s2_sphere_ff && (dist2 > SUMW'(s2_rsq_ff));

   logic               rsp_valid_ff;
   logic [VOXEL_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff & s2_inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= masked ? '0 : s2_voxel_ff;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/vcsm_checker.sv -----
// Port-level checks for volume_crop_sphere_mask, attached by bind.
// Depends on vcsm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module vcsm_checker
   import vcsm_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [VOXEL_W-1:0]     rsp_tdata,
   input wire logic                   rsp_tlast,
   input wire logic                   csr_psel,
   input wire logic                   csr_penable,
   input wire logic                   csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   input wire logic [CSR_DATA_W-1:0]  csr_prdata,
   input wire logic                   csr_pready
);

   logic               mode_sel;
   logic               mode_wr;
   logic               rsp_stall;
   logic               rd_mode;
   logic               wr_mode;
   logic [VOXEL_W:0]   rsp_word;

   assign mode_sel  = (csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB]) == CSR_MODE);
   assign mode_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready && mode_sel;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tlast, rsp_tdata};
   assign rd_mode   = csr_prdata[0];
   assign wr_mode   = csr_pwdata[0];

   // a held response keeps its payload
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // with nothing in the output register, requests are always taken
   `ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // reset empties the pipeline
   `ASSERT_NXT(a_reset_flush, clock, 1'b0, reset, !rsp_tvalid)

   // a mode write reads back on the next cycle
   `ASSERT_NXT(a_mode_readback, clock, reset, mode_wr, !mode_sel || (rd_mode == $past(wr_mode)))

endmodule

bind volume_crop_sphere_mask vcsm_checker u_vcsm_checker (.*);

`default_nettype wire
